### rtl/xcf_pkg.sv
// ----------------------------------------------------------------------------
// xcf_pkg
// Shared types and constants of the xor checksum packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package xcf_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxWords   = 4;
  localparam int unsigned WordIdxW   = $clog2(MaxWords);
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [ByteW-1:0] StartByteRst = 8'd170;

  // register byte addresses
  localparam logic [CfgAddrW-1:0] AddrStartByte = 3'd0;

  // command codes
  localparam logic CmdOpen    = 1'b0;
  localparam logic CmdPayload = 1'b1;

  typedef struct packed {
    logic             command;
    logic [ByteW-1:0] packet_id;
    logic [ByteW-1:0] payload_length;
    logic [ByteW-1:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
    logic             is_checksum;
    logic             protocol_error;
  } out_word_t;

  typedef struct packed {
    out_word_t [MaxWords-1:0] words;
    logic [WordIdxW-1:0]      last_idx;
  } bundle_t;

endpackage

`default_nettype wire

### rtl/xcf_cfg_regs.sv
// ----------------------------------------------------------------------------
// xcf_cfg_regs
// APB-style register port holding the frame start marker byte.
// ----------------------------------------------------------------------------
`default_nettype none

module xcf_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [xcf_pkg::CfgAddrW-1:0]   paddr,
  input  wire logic [xcf_pkg::CfgDataW-1:0]   pwdata,
  output logic      [xcf_pkg::CfgDataW-1:0]   prdata,
  output logic                                pready,
  output logic      [xcf_pkg::ByteW-1:0]      marker_byte_o
);

  logic [xcf_pkg::ByteW-1:0] marker_byte_q;
  logic [xcf_pkg::ByteW-1:0] marker_byte_d;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    marker_byte_d = marker_byte_q;
    if (wr_en && (paddr == xcf_pkg::AddrStartByte)) begin
      marker_byte_d = pwdata[xcf_pkg::ByteW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_byte_q <= xcf_pkg::StartByteRst;
    end else begin
      marker_byte_q <= marker_byte_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == xcf_pkg::AddrStartByte) begin
      prdata = {{(xcf_pkg::CfgDataW-xcf_pkg::ByteW){1'b0}}, marker_byte_q};
    end
  end

  assign marker_byte_o = marker_byte_q;

endmodule

`default_nettype wire

### rtl/xcf_frame_core.sv
// ----------------------------------------------------------------------------
// xcf_frame_core
// Frame state and the single-pass build of all words caused by one command.
// ----------------------------------------------------------------------------
`default_nettype none

module xcf_frame_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [xcf_pkg::ByteW-1:0] marker_byte_i,
  input  wire xcf_pkg::in_word_t         in_word_i,
  input  wire logic                      load_i,
  output xcf_pkg::bundle_t               bundle_o
);

  logic                      frame_open_q, frame_open_d;
  logic [xcf_pkg::ByteW-1:0] remaining_q, remaining_d;
  logic [xcf_pkg::ByteW-1:0] xor_q, xor_d;

  logic [xcf_pkg::ByteW-1:0] hdr_xor;
  logic [xcf_pkg::ByteW-1:0] data_xor;
  logic [xcf_pkg::ByteW-1:0] rem_dec;
  xcf_pkg::bundle_t          bundle;

  assign hdr_xor  = marker_byte_i ^ in_word_i.packet_id ^ in_word_i.payload_length;
  assign data_xor = xor_q ^ in_word_i.data_byte;
  assign rem_dec  = remaining_q - 8'd1;

  always_comb begin
    bundle       = '0;
    frame_open_d = frame_open_q;
    remaining_d  = remaining_q;
    xor_d        = xor_q;
    if (in_word_i.command == xcf_pkg::CmdOpen) begin
      bundle.words[0] = '{marker_byte_i, 1'b0, 1'b0, frame_open_q};
      bundle.words[1] = '{in_word_i.packet_id, 1'b0, 1'b0, frame_open_q};
      bundle.words[2] = '{in_word_i.payload_length, 1'b0, 1'b0, frame_open_q};
      if (in_word_i.payload_length == '0) begin
        bundle.words[3] = '{hdr_xor, 1'b0, 1'b1, frame_open_q};
        bundle.last_idx = 2'd3;
        frame_open_d    = 1'b0;
        remaining_d     = '0;
        xor_d           = '0;
      end else begin
        bundle.last_idx = 2'd2;
        frame_open_d    = 1'b1;
        remaining_d     = in_word_i.payload_length;
        xor_d           = hdr_xor;
      end
    end else if (!frame_open_q) begin
      // stray payload word: its data is dropped and one protocol error word is sent
      bundle.words[0] = '{'0, 1'b0, 1'b0, 1'b1};
      bundle.last_idx = 2'd0;
    end else begin
      bundle.words[0] = '{in_word_i.data_byte, 1'b0, 1'b0, 1'b0};
      remaining_d     = rem_dec;
      xor_d           = data_xor;
      if (rem_dec == '0) begin
        bundle.words[1] = '{data_xor, 1'b0, 1'b1, 1'b0};
        bundle.last_idx = 2'd1;
        frame_open_d    = 1'b0;
        xor_d           = '0;
      end else begin
        bundle.last_idx = 2'd0;
      end
    end
    for (int i = 0; i < xcf_pkg::MaxWords; i++) begin
      bundle.words[i].last = (bundle.last_idx == xcf_pkg::WordIdxW'(i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      remaining_q  <= '0;
      xor_q        <= '0;
    end else if (load_i) begin
      frame_open_q <= frame_open_d;
      remaining_q  <= remaining_d;
      xor_q        <= xor_d;
    end
  end

  assign bundle_o = bundle;

endmodule

`default_nettype wire

### rtl/xcf_serializer.sv
// ----------------------------------------------------------------------------
// xcf_serializer
// Result register holding one command's words, sent one word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module xcf_serializer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire xcf_pkg::bundle_t  bundle_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   load_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output xcf_pkg::out_word_t     out_word_o
);

  logic                                     valid_q;
  logic [xcf_pkg::WordIdxW-1:0]             idx_q;
  xcf_pkg::out_word_t [xcf_pkg::MaxWords-1:0] words_q;
  logic [xcf_pkg::WordIdxW-1:0]             last_idx_q;

  logic take;
  logic done;

  assign take       = valid_q & ~out_stall_i;
  assign done       = take & (idx_q == last_idx_q);
  assign in_stall_o = valid_q & ~done;
  assign load_o     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      words_q    <= bundle_i.words;
      last_idx_q <= bundle_i.last_idx;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = words_q[idx_q];

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q <= last_idx_q))
    else $error("word index beyond bundle");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |=> (valid_q && $stable(idx_q)))
    else $error("index moved while output stalled");

  a_load_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |=> (valid_q && (idx_q == '0)))
    else $error("new bundle did not start at first word");

endmodule

`default_nettype wire

### rtl/xor_checksum_packet_framer_top.sv
// ----------------------------------------------------------------------------
// xor_checksum_packet_framer_top
// Frames commands into start, id, length, payload and xor checksum bytes.
// The first word of a command is offered in the cycle after it is accepted.
// A command holds the result register until all its words, one to four, are
// sent; words go one per cycle while out_stall_i is low, back to back.
// Reset clears frame state and empties the result register; start byte is 170.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checksum_packet_framer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire xcf_pkg::in_word_t             in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output xcf_pkg::out_word_t                 out_word_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [xcf_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [xcf_pkg::CfgDataW-1:0]  pwdata,
  output logic      [xcf_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready
);

  logic [xcf_pkg::ByteW-1:0] marker_byte;
  logic                      load;
  xcf_pkg::bundle_t          bundle;

  xcf_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .marker_byte_o (marker_byte)
  );

  xcf_frame_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .marker_byte_i (marker_byte),
    .in_word_i     (in_word_i),
    .load_i        (load),
    .bundle_o      (bundle)
  );

  xcf_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bundle_i    (bundle),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .load_o      (load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
